>>> src/rcp_pkg.sv
// rcp_pkg: shared types and constants for the ROI crop / projection block.
// Used by rcp_ctrl, rcp_dp, the top level and the port checker.
package rcp_pkg;

	localparam int MAX_CROP_WIDTH = 32;
	localparam int MAX_FRAME_DIM  = 4096;

	localparam int COL_AW = (MAX_CROP_WIDTH > 1) ? $clog2(MAX_CROP_WIDTH) : 1;
	localparam int CFG_AW = 3;
	localparam int DIM_W  = 13;
	localparam int POS_W  = 12;
	localparam int PIX_W  = 16;
	localparam int SUM_W  = 40;

	// register indexes of the config port
	localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_WINDOW_X_FIRST = 3'd2;
	localparam logic [CFG_AW-1:0] REG_WINDOW_X_FINAL = 3'd3;
	localparam logic [CFG_AW-1:0] REG_WINDOW_Y_FIRST = 3'd4;
	localparam logic [CFG_AW-1:0] REG_WINDOW_Y_FINAL = 3'd5;

	typedef enum logic [1:0] {
		KIND_PIX = 2'd0,
		KIND_ROW = 2'd1,
		KIND_COL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_COL_RD,
		ST_COL_OUT
	} state_t;

	typedef struct packed {
		logic [DIM_W-1:0] frame_width;
		logic [DIM_W-1:0] frame_height;
		logic [POS_W-1:0] window_x_first;
		logic [POS_W-1:0] window_x_final;
		logic [POS_W-1:0] window_y_first;
		logic [POS_W-1:0] window_y_final;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic emit_row;
		logic col_rd;
		logic emit_col;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
		logic row_end;
		logic flush_pend;
		logic col_last;
	} sts_t;

endpackage

>>> src/rcp_ctrl.sv
// rcp_ctrl: sequencer for pixel accept, row-sum beat and column-sum flush.
// Depends on rcp_pkg; drives rcp_dp through cmd_t, reads sts_t.
module rcp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  rcp_pkg::sts_t sts,
	output rcp_pkg::cmd_t cmd,
	output logic          in_stall
);

	rcp_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rcp_pkg::ST_IDLE: begin
				if (cmd.accept && sts.row_end) begin
					state_nxt = rcp_pkg::ST_ROW;
				end
			end
			rcp_pkg::ST_ROW: begin
				if (sts.slot_free) begin
					state_nxt = sts.flush_pend ? rcp_pkg::ST_COL_RD : rcp_pkg::ST_IDLE;
				end
			end
			rcp_pkg::ST_COL_RD: begin
				state_nxt = rcp_pkg::ST_COL_OUT;
			end
			rcp_pkg::ST_COL_OUT: begin
				if (sts.slot_free) begin
					state_nxt = sts.col_last ? rcp_pkg::ST_IDLE : rcp_pkg::ST_COL_RD;
				end
			end
			default: begin
				state_nxt = rcp_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall     = !((state_q == rcp_pkg::ST_IDLE) && sts.slot_free);
		cmd.accept   = (state_q == rcp_pkg::ST_IDLE) && sts.slot_free && in_valid;
		cmd.emit_row = (state_q == rcp_pkg::ST_ROW) && sts.slot_free;
		cmd.col_rd   = (state_q == rcp_pkg::ST_COL_RD);
		cmd.emit_col = (state_q == rcp_pkg::ST_COL_OUT) && sts.slot_free;
	end

endmodule

>>> src/rcp_dp.sv
// rcp_dp: position counters, window test, row accumulator, column-sum store
// and output register. Depends on rcp_pkg; commanded by rcp_ctrl.
module rcp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rcp_pkg::cfg_t                      cfg,
	input  logic signed [rcp_pkg::PIX_W-1:0]   pixel,
	input  rcp_pkg::cmd_t                      cmd,
	output rcp_pkg::sts_t                      sts,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [1:0]                         kind,
	output logic [rcp_pkg::POS_W-1:0]          x_index,
	output logic [rcp_pkg::POS_W-1:0]          y_index,
	output logic signed [rcp_pkg::SUM_W-1:0]   value,
	output logic                               last
);

	localparam int PW = rcp_pkg::POS_W;
	localparam int SW = rcp_pkg::SUM_W;
	localparam int AW = rcp_pkg::COL_AW;
	localparam int NC = rcp_pkg::MAX_CROP_WIDTH;

	// frame geometry
	logic [PW-1:0] w_m1, h_m1, x_last, y_last;
	logic [PW-1:0] col_q, row_q;
	logic [PW-1:0] wx, wy, span;
	logic          in_win, row_end, win_end, col_end, frame_end, in_store;

	always_comb begin
		if (cfg.frame_width == '0) begin
			w_m1 = '0;
		end else if (cfg.frame_width > rcp_pkg::DIM_W'(rcp_pkg::MAX_FRAME_DIM)) begin
			w_m1 = PW'(rcp_pkg::MAX_FRAME_DIM - 1);
		end else begin
			w_m1 = PW'(cfg.frame_width - 1'b1);
		end
		if (cfg.frame_height == '0) begin
			h_m1 = '0;
		end else if (cfg.frame_height > rcp_pkg::DIM_W'(rcp_pkg::MAX_FRAME_DIM)) begin
			h_m1 = PW'(rcp_pkg::MAX_FRAME_DIM - 1);
		end else begin
			h_m1 = PW'(cfg.frame_height - 1'b1);
		end
		x_last = (cfg.window_x_final < w_m1) ? cfg.window_x_final : w_m1;
		y_last = (cfg.window_y_final < h_m1) ? cfg.window_y_final : h_m1;
	end

	assign in_win    = (row_q >= cfg.window_y_first) && (row_q <= y_last) &&
	                   (col_q >= cfg.window_x_first) && (col_q <= x_last);
	assign wx        = col_q - cfg.window_x_first;
	assign wy        = row_q - cfg.window_y_first;
	assign span      = x_last - cfg.window_x_first;
	assign row_end   = in_win && (col_q == x_last);
	assign win_end   = row_end && (row_q == y_last);
	assign col_end   = (col_q >= w_m1);
	assign frame_end = col_end && (row_q >= h_m1);
	assign in_store  = (wx < PW'(NC));

	logic [SW-1:0] pix_ext;
	assign pix_ext = {{(SW - rcp_pkg::PIX_W){pixel[rcp_pkg::PIX_W-1]}}, pixel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// row accumulator; sum latched for the row beat
	logic [SW-1:0] row_acc_q, row_sum_q, acc_sum;
	logic [PW-1:0] row_y_q;
	logic          flush_pend_q;
	logic [AW-1:0] flush_last_q;

	assign acc_sum = row_acc_q + pix_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_acc_q    <= '0;
			flush_pend_q <= 1'b0;
		end else if (cmd.accept) begin
			flush_pend_q <= win_end;
			if (row_end || frame_end) begin
				row_acc_q <= '0;
			end else if (in_win) begin
				row_acc_q <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && row_end) begin
			row_sum_q <= acc_sum;
			row_y_q   <= wy;
		end
		if (cmd.accept && win_end) begin
			flush_last_q <= (span >= PW'(NC - 1)) ? AW'(NC - 1) : span[AW-1:0];
		end
	end

	// column store: read at accept, read-add-write in the cycle after
	logic [SW-1:0]           col_mem [NC];
	logic [SW-1:0]           rd_q, col_base, col_new, col_out;
	logic [NC-1:0]           vld_q;
	logic                    wr_s1_q, clr_s1_q, fwd_q;
	logic [AW-1:0]           wx_s1, fwd_addr_q, k_q, rd_addr;
	logic [rcp_pkg::PIX_W-1:0] pix_s1;
	logic [SW-1:0]           fwd_data_q;
	logic                    flush_done;

	assign rd_addr    = cmd.accept ? wx[AW-1:0] : k_q;
	assign col_base   = (fwd_q && (fwd_addr_q == wx_s1)) ? fwd_data_q :
	                    (vld_q[wx_s1] ? rd_q : '0);
	assign col_new    = col_base + {{(SW - rcp_pkg::PIX_W){pix_s1[rcp_pkg::PIX_W-1]}}, pix_s1};
	assign col_out    = vld_q[k_q] ? rd_q : '0;
	assign flush_done = cmd.emit_col && (k_q == flush_last_q);

	always_ff @(posedge clk) begin
		if (wr_s1_q) begin
			col_mem[wx_s1] <= col_new;
		end
		if (cmd.accept || cmd.col_rd) begin
			rd_q <= col_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1_q  <= 1'b0;
			clr_s1_q <= 1'b0;
			fwd_q    <= 1'b0;
			vld_q    <= '0;
			k_q      <= '0;
		end else begin
			wr_s1_q  <= cmd.accept && in_win && in_store;
			// frame end without a flush clears the store after this pixel lands
			clr_s1_q <= cmd.accept && frame_end && !win_end;
			fwd_q    <= wr_s1_q && !clr_s1_q;
			if (clr_s1_q || flush_done) begin
				vld_q <= '0;
			end else if (wr_s1_q) begin
				vld_q[wx_s1] <= 1'b1;
			end
			if (cmd.emit_col) begin
				k_q <= flush_done ? '0 : k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			wx_s1  <= wx[AW-1:0];
			pix_s1 <= pixel;
		end
		if (wr_s1_q) begin
			fwd_addr_q <= wx_s1;
			fwd_data_q <= col_new;
		end
	end

	// output register
	logic          out_valid_q, last_q;
	rcp_pkg::kind_t kind_q;
	logic [PW-1:0] x_q, y_q;
	logic [SW-1:0] value_q;
	logic          slot_free, load_pix;

	assign slot_free = !out_valid_q || !out_stall;
	assign load_pix  = cmd.accept && in_win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_pix || cmd.emit_row || cmd.emit_col) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pix) begin
			kind_q  <= rcp_pkg::KIND_PIX;
			x_q     <= wx;
			y_q     <= wy;
			value_q <= pix_ext;
			last_q  <= 1'b0;
		end else if (cmd.emit_row) begin
			kind_q  <= rcp_pkg::KIND_ROW;
			x_q     <= '0;
			y_q     <= row_y_q;
			value_q <= row_sum_q;
			last_q  <= 1'b0;
		end else if (cmd.emit_col) begin
			kind_q  <= rcp_pkg::KIND_COL;
			x_q     <= PW'(k_q);
			y_q     <= '0;
			value_q <= col_out;
			last_q  <= (k_q == flush_last_q);
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign x_index   = x_q;
	assign y_index   = y_q;
	assign value     = value_q;
	assign last      = last_q;

	assign sts.slot_free  = slot_free;
	assign sts.row_end    = row_end;
	assign sts.flush_pend = flush_pend_q;
	assign sts.col_last   = (k_q == flush_last_q);

endmodule

>>> src/roi_crop_with_projections.sv
// roi_crop_with_projections: top level; config registers, controller, datapath.
// Depends on rcp_pkg, rcp_ctrl and rcp_dp.
//
// Takes a frame in raster order, one signed 16-bit pixel per input beat, and
// tracks column and row itself. Pixels inside the inclusive window
// [window_x_first..window_x_final] x [window_y_first..window_y_final] come out
// as kind 0 beats with window-relative x/y. At the last window column of each
// window row a kind 1 beat carries that row's 40-bit sum (x_index 0). After
// the final window pixel, one kind 2 beat per window column (up to
// MAX_CROP_WIDTH, y_index 0) carries the column sums, last set on the final
// one. Column and row sums are cleared after the flush and at frame end.
// Window edges past the frame are clipped to the frame; frame sizes of 0
// count as 1, sizes above MAX_FRAME_DIM count as MAX_FRAME_DIM.
//
// Rate: one pixel per cycle while the output side keeps up; every beat goes
// through a single output register, so the input stalls while that register
// is full and stalled. A row end also stalls the input for the row-sum beat.
// The column flush, at most once per frame, stalls it while each column in
// turn is read from the registered column-sum memory and then sent as a beat.
//
// Config writes take effect at once and are expected only while idle.
module roi_crop_with_projections (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rcp_pkg::CFG_AW-1:0]          cfg_index,
	input  logic [rcp_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [rcp_pkg::PIX_W-1:0]    pixel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [1:0]                          kind,
	output logic [rcp_pkg::POS_W-1:0]           x_index,
	output logic [rcp_pkg::POS_W-1:0]           y_index,
	output logic signed [rcp_pkg::SUM_W-1:0]    value,
	output logic                                last
);

	rcp_pkg::cfg_t cfg_q;
	rcp_pkg::cmd_t cmd;
	rcp_pkg::sts_t sts;

	// config register file, reset to a full-size frame and a 32x32 window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= rcp_pkg::DIM_W'(rcp_pkg::MAX_FRAME_DIM);
			cfg_q.frame_height   <= rcp_pkg::DIM_W'(rcp_pkg::MAX_FRAME_DIM);
			cfg_q.window_x_first <= '0;
			cfg_q.window_x_final <= rcp_pkg::POS_W'(31);
			cfg_q.window_y_first <= '0;
			cfg_q.window_y_final <= rcp_pkg::POS_W'(31);
		end else if (cfg_we) begin
			case (cfg_index)
				rcp_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data;
				rcp_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data;
				rcp_pkg::REG_WINDOW_X_FIRST: cfg_q.window_x_first <= cfg_data[rcp_pkg::POS_W-1:0];
				rcp_pkg::REG_WINDOW_X_FINAL: cfg_q.window_x_final <= cfg_data[rcp_pkg::POS_W-1:0];
				rcp_pkg::REG_WINDOW_Y_FIRST: cfg_q.window_y_first <= cfg_data[rcp_pkg::POS_W-1:0];
				rcp_pkg::REG_WINDOW_Y_FINAL: cfg_q.window_y_final <= cfg_data[rcp_pkg::POS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	rcp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pixel     (pixel),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.kind      (kind),
		.x_index   (x_index),
		.y_index   (y_index),
		.value     (value),
		.last      (last)
	);

endmodule

>>> src/rcp_chk.sv
// rcp_chk: port-level checks on roi_crop_with_projections, attached by bind.
// Depends on rcp_pkg.
module rcp_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [1:0]                       kind,
	input logic [rcp_pkg::POS_W-1:0]        x_index,
	input logic [rcp_pkg::POS_W-1:0]        y_index,
	input logic signed [rcp_pkg::SUM_W-1:0] value,
	input logic                             last
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(kind))
		else $error("stalled output beat changed");

	// last only on a column-sum beat
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == rcp_pkg::KIND_COL)
		else $error("last on a non column-sum beat");

	// row-sum beats carry x_index 0, column-sum beats y_index 0
	a_row_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rcp_pkg::KIND_ROW |-> x_index == '0)
		else $error("row sum with nonzero x_index");

	a_col_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rcp_pkg::KIND_COL |-> y_index == '0 &&
		x_index < rcp_pkg::POS_W'(rcp_pkg::MAX_CROP_WIDTH))
		else $error("column sum index out of range");

	// a pixel beat carries a 16-bit sign-extended value
	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == rcp_pkg::KIND_PIX |->
		(value[rcp_pkg::SUM_W-1:rcp_pkg::PIX_W-1] == '0 ||
		 value[rcp_pkg::SUM_W-1:rcp_pkg::PIX_W-1] == '1))
		else $error("pixel beat value not a sign-extended pixel");

endmodule

bind roi_crop_with_projections rcp_chk u_rcp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.kind      (kind),
	.x_index   (x_index),
	.y_index   (y_index),
	.value     (value),
	.last      (last)
);

>>> sim/roi_crop_with_projections_test.sv
`timescale 1ns / 100ps
// roi_crop_with_projections_test: self-checking bench for the ROI crop / projection block.
// Depends on rcp_pkg and roi_crop_with_projections; holds its own predictor of the block.

module roi_crop_with_projections_test;

	// generous limit for the slowest legal run
	localparam int CYCLE_LIMIT  = 400000;
	// enough for a full column flush plus margin; covers work left behind by silent pixels
	localparam int DRAIN_CYCLES = 2 * rcp_pkg::MAX_CROP_WIDTH + 16;
	localparam int HOLD_CYCLES  = 200;
	localparam int SHOW_LIMIT   = 20;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [rcp_pkg::CFG_AW-1:0]          cfg_index = '0;
	logic [rcp_pkg::DIM_W-1:0]           cfg_data  = '0;
	logic                                in_valid  = 1'b0;
	logic                                in_stall;
	logic signed [rcp_pkg::PIX_W-1:0]    pixel     = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [1:0]                          kind;
	logic [rcp_pkg::POS_W-1:0]           x_index;
	logic [rcp_pkg::POS_W-1:0]           y_index;
	logic signed [rcp_pkg::SUM_W-1:0]    value;
	logic                                last;

	roi_crop_with_projections u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.x_index   (x_index),
		.y_index   (y_index),
		.value     (value),
		.last      (last)
	);

	always #5 clk = ~clk;

	// one output beat as the block should produce it
	typedef struct {
		rcp_pkg::kind_t              b_kind;
		logic [rcp_pkg::POS_W-1:0]   b_x;
		logic [rcp_pkg::POS_W-1:0]   b_y;
		logic [rcp_pkg::SUM_W-1:0]   b_value;
		logic                        b_last;
	} beat_t;

	beat_t due_beats[$];

	// mirror of the register file, at reset values
	logic [rcp_pkg::DIM_W-1:0] cfg_fw = 13'd4096;
	logic [rcp_pkg::DIM_W-1:0] cfg_fh = 13'd4096;
	logic [rcp_pkg::POS_W-1:0] cfg_xf = 12'd0;
	logic [rcp_pkg::POS_W-1:0] cfg_xl = 12'd31;
	logic [rcp_pkg::POS_W-1:0] cfg_yf = 12'd0;
	logic [rcp_pkg::POS_W-1:0] cfg_yl = 12'd31;

	// mirror of the block's raster position and accumulators
	int                        col_at = 0;
	int                        row_at = 0;
	logic [rcp_pkg::SUM_W-1:0] row_total = '0;
	logic [rcp_pkg::SUM_W-1:0] column_total [rcp_pkg::MAX_CROP_WIDTH];

	int errors        = 0;
	int pixels_sent   = 0;
	int beats_checked = 0;
	int cycles        = 0;
	int idle_pct      = 0;   // chance per cycle that the sender sits out
	int stall_pct     = 0;   // chance per cycle that the receiver stalls
	int hold_token    = 0;   // bumped by a test to ask for one long output hold
	int hold_seen     = 0;
	int hold_left     = 0;

	initial begin
		for (int k = 0; k < rcp_pkg::MAX_CROP_WIDTH; k++)
			column_total[k] = '0;
	end

	function automatic int clamp_dim(input logic [rcp_pkg::DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > rcp_pkg::MAX_FRAME_DIM)
			return rcp_pkg::MAX_FRAME_DIM;
		return int'(d);
	endfunction

	function automatic void queue_beat(input rcp_pkg::kind_t k, input int x, input int y,
			input logic [rcp_pkg::SUM_W-1:0] v, input logic fin);
		beat_t b;
		b.b_kind  = k;
		b.b_x     = x[rcp_pkg::POS_W-1:0];
		b.b_y     = y[rcp_pkg::POS_W-1:0];
		b.b_value = v;
		b.b_last  = fin;
		due_beats.push_back(b);
	endfunction

	// Advance the raster by one pixel and queue whatever beats it causes.
	function automatic void crop_and_project(input logic signed [rcp_pkg::PIX_W-1:0] p);
		int                        w;
		int                        h;
		int                        xl;
		int                        yl;
		int                        wx;
		int                        wy;
		int                        cnt;
		logic [rcp_pkg::SUM_W-1:0] ext;
		w   = clamp_dim(cfg_fw);
		h   = clamp_dim(cfg_fh);
		// window edges past the frame are pulled back to the frame edge
		xl  = (int'(cfg_xl) < w - 1) ? int'(cfg_xl) : w - 1;
		yl  = (int'(cfg_yl) < h - 1) ? int'(cfg_yl) : h - 1;
		ext = {{(rcp_pkg::SUM_W - rcp_pkg::PIX_W){p[rcp_pkg::PIX_W-1]}}, p};
		if (row_at >= int'(cfg_yf) && row_at <= yl &&
				col_at >= int'(cfg_xf) && col_at <= xl) begin
			wx = col_at - int'(cfg_xf);
			wy = row_at - int'(cfg_yf);
			queue_beat(rcp_pkg::KIND_PIX, wx, wy, ext, 1'b0);
			row_total = row_total + ext;
			// columns beyond the store go into the row sum only
			if (wx < rcp_pkg::MAX_CROP_WIDTH)
				column_total[wx] = column_total[wx] + ext;
			if (col_at == xl) begin
				queue_beat(rcp_pkg::KIND_ROW, 0, wy, row_total, 1'b0);
				row_total = '0;
				if (row_at == yl) begin
					cnt = xl - int'(cfg_xf) + 1;
					if (cnt > rcp_pkg::MAX_CROP_WIDTH)
						cnt = rcp_pkg::MAX_CROP_WIDTH;
					for (int k = 0; k < cnt; k++)
						queue_beat(rcp_pkg::KIND_COL, k, 0, column_total[k], k + 1 == cnt);
					for (int k = 0; k < rcp_pkg::MAX_CROP_WIDTH; k++)
						column_total[k] = '0;
				end
			end
		end
		if (col_at + 1 >= w) begin
			col_at = 0;
			if (row_at + 1 >= h) begin
				// frame end clears everything
				row_at    = 0;
				row_total = '0;
				for (int k = 0; k < rcp_pkg::MAX_CROP_WIDTH; k++)
					column_total[k] = '0;
			end else begin
				row_at = (row_at + 1) & 12'hFFF;
			end
		end else begin
			col_at = (col_at + 1) & 12'hFFF;
		end
	endfunction

	// Register write; only called with the block idle.
	task automatic write_reg(input logic [rcp_pkg::CFG_AW-1:0] idx, input int data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data[rcp_pkg::DIM_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rcp_pkg::REG_FRAME_WIDTH:    cfg_fw = data[rcp_pkg::DIM_W-1:0];
			rcp_pkg::REG_FRAME_HEIGHT:   cfg_fh = data[rcp_pkg::DIM_W-1:0];
			rcp_pkg::REG_WINDOW_X_FIRST: cfg_xf = data[rcp_pkg::POS_W-1:0];
			rcp_pkg::REG_WINDOW_X_FINAL: cfg_xl = data[rcp_pkg::POS_W-1:0];
			rcp_pkg::REG_WINDOW_Y_FIRST: cfg_yf = data[rcp_pkg::POS_W-1:0];
			rcp_pkg::REG_WINDOW_Y_FINAL: cfg_yl = data[rcp_pkg::POS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_window(input int fw, input int fh, input int xf, input int xl,
			input int yf, input int yl);
		write_reg(rcp_pkg::REG_FRAME_WIDTH, fw);
		write_reg(rcp_pkg::REG_FRAME_HEIGHT, fh);
		write_reg(rcp_pkg::REG_WINDOW_X_FIRST, xf);
		write_reg(rcp_pkg::REG_WINDOW_X_FINAL, xl);
		write_reg(rcp_pkg::REG_WINDOW_Y_FIRST, yf);
		write_reg(rcp_pkg::REG_WINDOW_Y_FINAL, yl);
	endtask

	// Offer one pixel beat, with random idle cycles in front, and hold it until taken.
	task automatic send_pixel(input logic signed [rcp_pkg::PIX_W-1:0] p);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= p;
		do
			@(posedge clk);
		while (in_stall);
		crop_and_project(p);
		pixels_sent++;
	endtask

	// Mostly random values, with the field extremes and sign boundary mixed in.
	function automatic logic signed [rcp_pkg::PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'shFFFF;
			3: return 16'sh0000;
			default: return rcp_pkg::PIX_W'($urandom);
		endcase
	endfunction

	task automatic send_frame(input int n);
		for (int k = 0; k < n; k++)
			send_pixel(pick_pixel());
	endtask

	// Stop offering, wait for every due beat, then let any trailing work settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mix(input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
	endtask

	// Register reset values: 4096 x 4096 frame with a 32 x 32 window at the origin.
	task automatic test_reset_defaults();
		set_mix(0, 0);
		send_pixel(16'sh7FFF);
		send_pixel(16'sh8000);
		send_pixel(16'shFFFF);
		drain();
	endtask

	// Zero frame size counts as one pixel; window finals of 4095 clip to it.
	// Every pixel is a whole frame: pixel, row sum, single column sum with last.
	task automatic test_tiny_frame();
		set_mix(0, 0);
		set_window(0, 0, 0, 4095, 0, 4095);
		send_pixel(16'sh1234);   // first one only realigns the raster left from before
		send_pixel(16'sh8000);
		send_pixel(16'sh7FFF);
		send_pixel(16'shFFFF);
		send_pixel(16'sh0000);
		drain();
	endtask

	// First beyond final in x, then in y: nothing may come out.
	task automatic test_inverted_window();
		set_mix(36, 36);
		set_window(4, 2, 3, 1, 0, 1);
		send_frame(8);
		drain();
		set_window(4, 2, 0, 3, 1, 0);
		send_frame(8);
		drain();
	endtask

	// Window running off the right and bottom edges still closes rows and flushes.
	task automatic test_clipped_window();
		set_mix(36, 36);
		set_window(3, 2, 1, 4095, 0, 4095);
		send_frame(6);
		drain();
	endtask

	// Window wider than the column store: 36 row pixels, only 32 column sums.
	task automatic test_wide_window();
		set_mix(0, 63);
		set_window(36, 1, 0, 35, 0, 0);
		send_frame(36);
		drain();
	endtask

	// Frame registers just above 4096 clamp to 4096: the row closes at column 3
	// with no flush, since the bottom window row clips to row 4095.
	task automatic test_oversized_frame();
		set_mix(0, 0);
		set_window(4097, 4097, 0, 3, 0, 4095);
		send_frame(6);
		drain();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering,
	// so the output register fills and the input side has to stall.
	task automatic test_backpressure();
		set_mix(0, 0);
		set_window(6, 4, 0, 5, 0, 3);
		hold_token++;
		send_frame(24);
		drain();
	endtask

	// Random small windows, including the odd clipped, inverted, wide or zero-sized one.
	task automatic random_window(output int n);
		int w;
		int h;
		int xf;
		int xl;
		int yf;
		int yl;
		w  = $urandom_range(1, 8);
		h  = $urandom_range(1, 5);
		xf = $urandom_range(0, w - 1);
		xl = $urandom_range(xf, w - 1);
		yf = $urandom_range(0, h - 1);
		yl = $urandom_range(yf, h - 1);
		case ($urandom_range(0, 11))
			0: xl = 4095;
			1: yl = 4095;
			2: xf = $urandom_range(0, 4095);
			3: yf = $urandom_range(0, 4095);
			4: xl = $urandom_range(0, 4095);
			5: yl = $urandom_range(0, 4095);
			6: w  = 0;
			7: h  = 0;
			8: begin
				w  = $urandom_range(33, 40);
				h  = 1;
				xf = $urandom_range(0, 3);
				xl = w - 1;
				yf = 0;
				yl = 0;
			end
			default: ;
		endcase
		set_window(w, h, xf, xl, yf, yl);
		n = clamp_dim(rcp_pkg::DIM_W'(w)) * clamp_dim(rcp_pkg::DIM_W'(h));
		if (n > 12)
			n = 12;
	endtask

	task automatic run_random_frames(input int idle, input int stall);
		int start;
		int n;
		start = pixels_sent;
		set_mix(idle, stall);
		while (pixels_sent - start < 6) begin
			random_window(n);
			send_frame(n);
			drain();
		end
	endtask

	task automatic test_random_mixes();
		run_random_frames(0, 0);
		run_random_frames(63, 0);
		run_random_frames(0, 63);
		run_random_frames(36, 36);
	endtask

	// Receiver side: random stalls, or a long hold when a test asks for one.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Every accepted output beat against the oldest due beat.
	always @(posedge clk) begin : check_beat
		beat_t due;
		if (arst_n && out_valid && !out_stall) begin
			beats_checked++;
			if (due_beats.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: unexpected beat kind %0d x %0d y %0d value %0d last %0b",
						$time, kind, x_index, y_index, value, last);
			end else begin
				due = due_beats.pop_front();
				if (kind !== due.b_kind || x_index !== due.b_x || y_index !== due.b_y ||
						value !== due.b_value || last !== due.b_last) begin
					errors++;
					if (errors <= SHOW_LIMIT)
						$display("%0t: mismatch expected kind %0d x %0d y %0d value %0d last %0b,",
							$time, due.b_kind, due.b_x, due.b_y, $signed(due.b_value),
							due.b_last, " got kind %0d x %0d y %0d value %0d last %0b",
							kind, x_index, y_index, value, last);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still due", cycles, due_beats.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_tiny_frame();
		test_inverted_window();
		test_clipped_window();
		test_wide_window();
		test_oversized_frame();
		test_backpressure();
		test_random_mixes();

		$display("covered %0d pixels in, %0d output beats checked, %0d errors", pixels_sent,
			beats_checked, errors);
		$display("reset window, clamped/clipped/inverted/wide windows, long hold, idle mixes");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
